// File: hdl/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared constants and types for the LFU cache policy block.
// ----------------------------------------------------------------------------
package lfuc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CAP_W = 5;
    localparam int KEY_W = 32;
    localparam int VAL_W = 31;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes carried on s_tuser
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    // per-cell update control
    typedef struct packed {
        logic apply;   // update step fires this cycle
        logic at_pos;  // this cell holds the touched or inserted slot
    } cell_ctl_t;

endpackage

// File: hdl/lfu_cache_policy_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_policy_top
// LFU key-value store with LRU tie-break, kept as a chain of slot cells
// ordered by descending use count.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction compares the key in every cell and registers
// the outcome; the update step then shifts the chain one slot, places the entry
// and loads the output register. No new transaction is taken until that step.
// The update step waits while a previous result is held by m_tready low.
// Reset: occupancy cleared and capacity set to 16; entry storage is not
// cleared, so the block accepts transactions right after reset.
// ----------------------------------------------------------------------------
module lfu_cache_policy_top #(
    parameter int MAX_ENTRIES = lfuc_pkg::MAX_ENTRIES_DEF,
    parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [lfuc_pkg::CAP_W-1:0] cfg_wdata,   // capacity
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,     // [31:0] key, [62:32] value
    input  logic [0:0]                 s_tuser,     // [0] mode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,     // [30:0] value_out
    output logic [0:0]                 m_tuser      // [0] found
);

    localparam int OW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (OW > lfuc_pkg::CAP_W) ? OW : lfuc_pkg::CAP_W;
    localparam int KW = lfuc_pkg::KEY_W;
    localparam int VW = lfuc_pkg::VAL_W;

    logic [lfuc_pkg::CAP_W-1:0] cap_reg;
    logic [OW-1:0]              occ_reg;
    logic                       busy_reg;
    logic                       m_tvalid_reg;
    logic                       found_reg;
    logic [VW-1:0]              vout_reg;

    // registered by the compare cycle
    logic [MAX_ENTRIES-1:0]     pos_reg;
    logic                       apply_reg;
    logic                       ins_reg;
    logic [OW-1:0]              occ_new_reg;
    logic [KW-1:0]              key_reg;
    logic [VW-1:0]              mv_val_reg;
    logic [COUNT_WIDTH-1:0]     mv_cnt_reg;
    logic                       st_found_reg;
    logic [VW-1:0]              st_val_reg;

    logic                       in_mode;
    logic [KW-1:0]              in_key;
    logic [VW-1:0]              in_val;
    logic                       accept;
    logic                       fire;

    logic [KW-1:0]              cell_key [MAX_ENTRIES];
    logic [VW-1:0]              cell_val [MAX_ENTRIES];
    logic [COUNT_WIDTH-1:0]     cell_cnt [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     match_c;
    logic [MAX_ENTRIES-1:0]     le_c;
    logic [MAX_ENTRIES-1:0]     seen_c;
    logic [MAX_ENTRIES-1:0]     used_c;
    logic [MAX_ENTRIES-1:0]     ins_dec;

    logic                       hit;
    logic [VW-1:0]              sel_val;
    logic [COUNT_WIDTH-1:0]     sel_cnt;
    logic [LW-1:0]              lim;
    logic [LW-1:0]              ins_idx;
    logic [LW-1:0]              occ_ext;

    assign in_mode = s_tuser[0];
    assign in_key  = s_tdata[KW-1:0];
    assign in_val  = s_tdata[KW+VW-1:KW];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign fire     = busy_reg && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {1'b0, vout_reg};

    assign occ_ext = LW'(occ_reg);

    always_comb begin
        if (LW'(cap_reg) > LW'(MAX_ENTRIES)) begin
            lim = LW'(MAX_ENTRIES);
        end else begin
            lim = LW'(cap_reg);
        end
        // store full (or capacity lowered): insertion point is slot lim-1, whose entry is replaced
        if (occ_ext >= lim) begin
            ins_idx = lim - LW'(1);
        end else begin
            ins_idx = occ_ext;
        end
    end

    always_comb begin
        hit     = |match_c;
        sel_val = '0;
        sel_cnt = '0;
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            used_c[j]  = LW'(j) < occ_ext;
            ins_dec[j] = ins_idx == LW'(j);
            sel_val    = sel_val | (cell_val[j] & {VW{match_c[j]}});
            sel_cnt    = sel_cnt | (cell_cnt[j] & {COUNT_WIDTH{match_c[j]}});
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            lfuc_pkg::cell_ctl_t ctl;
            logic [KW-1:0]          lk;
            logic [VW-1:0]          lv;
            logic [COUNT_WIDTH-1:0] lcnt;
            logic                   lle;
            logic                   rseen;

            assign ctl.apply  = fire && apply_reg;
            assign ctl.at_pos = pos_reg[g];

            if (g == 0) begin : g_head
                assign lk   = '0;
                assign lv   = '0;
                assign lcnt = '0;
                assign lle  = 1'b0;
            end else begin : g_body
                assign lk   = cell_key[g-1];
                assign lv   = cell_val[g-1];
                assign lcnt = cell_cnt[g-1];
                assign lle  = le_c[g-1];
            end

            if (g == MAX_ENTRIES - 1) begin : g_tail
                assign rseen = 1'b0;
            end else begin : g_mid
                assign rseen = seen_c[g+1];
            end

            lfuc_cell #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .used       (used_c[g]),
                .cmp_key    (in_key),
                .match      (match_c[g]),
                .mv_key     (key_reg),
                .mv_val     (mv_val_reg),
                .mv_cnt     (mv_cnt_reg),
                .left_key   (lk),
                .left_val   (lv),
                .left_cnt   (lcnt),
                .left_le    (lle),
                .right_seen (rseen),
                .seen_out   (seen_c[g]),
                .le_out     (le_c[g]),
                .key_out    (cell_key[g]),
                .val_out    (cell_val[g]),
                .cnt_out    (cell_cnt[g])
            );
        end
    endgenerate

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= lfuc_pkg::CAP_RESET;
            occ_reg      <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (fire) begin
                busy_reg <= 1'b0;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
                if (ins_reg) begin
                    occ_reg <= occ_new_reg;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg      <= in_key;
            pos_reg      <= hit ? match_c : ins_dec;
            occ_new_reg  <= OW'(ins_idx + LW'(1));
            ins_reg      <= (in_mode == lfuc_pkg::MODE_SET) && !hit && (lim != '0);
            apply_reg    <= (in_mode == lfuc_pkg::MODE_GET) ? hit : (lim != '0);
            mv_val_reg   <= (in_mode == lfuc_pkg::MODE_SET) ? in_val : sel_val;
            if (!hit) begin
                mv_cnt_reg <= COUNT_WIDTH'(1);
            end else if (sel_cnt == {COUNT_WIDTH{1'b1}}) begin
                mv_cnt_reg <= sel_cnt;
            end else begin
                mv_cnt_reg <= sel_cnt + COUNT_WIDTH'(1);
            end
            st_found_reg <= hit;
            st_val_reg   <= ((in_mode == lfuc_pkg::MODE_GET) && hit) ? sel_val : '0;
        end
        if (fire) begin
            found_reg <= st_found_reg;
            vout_reg  <= st_val_reg;
        end
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LW'(occ_reg) <= LW'(MAX_ENTRIES))
        else $error("occupancy exceeds entry count");

    a_pos_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot0(pos_reg))
        else $error("update targets more than one slot");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ins_reg) |=> (occ_reg != '0))
        else $error("insert left store empty");

    a_result_after_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(busy_reg))
        else $error("result without a pending transaction");

endmodule

// File: hdl/lfuc_cell.sv
// ----------------------------------------------------------------------------
// lfuc_cell
// One slot of the ordered entry list: holds key, value and use count,
// compares its key, and on an update either keeps its entry, takes its left
// neighbor's entry (shift toward the tail) or takes the promoted entry.
// ----------------------------------------------------------------------------
module lfuc_cell #(
    parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  lfuc_pkg::cell_ctl_t        ctl,
    input  logic                       used,
    input  logic [lfuc_pkg::KEY_W-1:0] cmp_key,
    output logic                       match,
    input  logic [lfuc_pkg::KEY_W-1:0] mv_key,
    input  logic [lfuc_pkg::VAL_W-1:0] mv_val,
    input  logic [COUNT_WIDTH-1:0]     mv_cnt,
    input  logic [lfuc_pkg::KEY_W-1:0] left_key,
    input  logic [lfuc_pkg::VAL_W-1:0] left_val,
    input  logic [COUNT_WIDTH-1:0]     left_cnt,
    input  logic                       left_le,
    input  logic                       right_seen,
    output logic                       seen_out,
    output logic                       le_out,
    output logic [lfuc_pkg::KEY_W-1:0] key_out,
    output logic [lfuc_pkg::VAL_W-1:0] val_out,
    output logic [COUNT_WIDTH-1:0]     cnt_out
);

    logic [lfuc_pkg::KEY_W-1:0] key_reg;
    logic [lfuc_pkg::VAL_W-1:0] val_reg;
    logic [COUNT_WIDTH-1:0]     cnt_reg;
    logic                       shift_in;
    logic                       load_mv;

    assign match    = used && (key_reg == cmp_key);
    assign seen_out = ctl.at_pos | right_seen;
    // right_seen: the touched slot lies further down, so this entry is a
    // candidate to be passed over
    assign le_out   = right_seen && (cnt_reg <= mv_cnt);
    assign shift_in = (right_seen || ctl.at_pos) && left_le;
    assign load_mv  = (le_out || ctl.at_pos) && !left_le;

    assign key_out = key_reg;
    assign val_out = val_reg;
    assign cnt_out = cnt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.apply) begin
            if (shift_in) begin
                key_reg <= left_key;
                val_reg <= left_val;
                cnt_reg <= left_cnt;
            end else if (load_mv) begin
                key_reg <= mv_key;
                val_reg <= mv_val;
                cnt_reg <= mv_cnt;
            end
        end
    end

endmodule
